@@ hw/rtl/pmc_pkg.sv @@
// shared constants, types and helpers for the pixel match centroid block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 13;
  localparam int POS_W   = 12;
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 25;
  localparam int COORD_W = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE  = 2'd2;

  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 13'd1200;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 13'd530;
  localparam logic [PIX_W-1:0]  RST_MATCH_VALUE  = 8'd100;

  localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ = SIZE_W'(MAX_HEIGHT);

  // frame totals handed from the accumulator to the sequencer
  typedef struct packed {
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
    logic [CNT_W-1:0] hit_count;
  } frame_tot_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // zero counts as one, anything above the limit saturates
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pmc_accum.sv @@
// raster position tracking, match test and coordinate sums, plus the config registers
// depends on pmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmc_accum (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            pix_accept,
  input  wire logic [pmc_pkg::PIX_W-1:0]       pixel,
  output pmc_pkg::frame_tot_t                  frame_tot,
  output logic                                 frame_done
);
  import pmc_pkg::*;

  logic [SIZE_W-1:0] width_r, height_r;
  logic [PIX_W-1:0]  match_r;

  logic [POS_W-1:0]  col_r, col_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [SUM_W-1:0]  csum_r, csum_nxt;
  logic [SUM_W-1:0]  rsum_r, rsum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  frame_tot_t        snap_r;
  logic              done_r;

  logic [SIZE_W-1:0] w_eff, h_eff;
  logic              hit, row_end, frame_end;
  logic [SUM_W-1:0]  csum_add, rsum_add;
  logic [CNT_W-1:0]  cnt_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      match_r  <= RST_MATCH_VALUE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_data;
        REG_FRAME_HEIGHT: height_r <= cfg_data;
        REG_MATCH_VALUE:  match_r  <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff     = clamp_size(width_r, MAX_WIDTH_SZ);
    h_eff     = clamp_size(height_r, MAX_HEIGHT_SZ);
    hit       = (pixel == match_r);
    csum_add  = csum_r + (hit ? SUM_W'(col_r) : '0);
    rsum_add  = rsum_r + (hit ? SUM_W'(row_r) : '0);
    cnt_add   = cnt_r + (hit ? CNT_W'(1) : '0);
    row_end   = ({1'b0, col_r} + SIZE_W'(1)) >= w_eff;
    frame_end = row_end && (({1'b0, row_r} + SIZE_W'(1)) >= h_eff);

    col_nxt  = col_r;
    row_nxt  = row_r;
    csum_nxt = csum_r;
    rsum_nxt = rsum_r;
    cnt_nxt  = cnt_r;
    if (pix_accept) begin
      if (frame_end) begin
        col_nxt  = '0;
        row_nxt  = '0;
        csum_nxt = '0;
        rsum_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        csum_nxt = csum_add;
        rsum_nxt = rsum_add;
        cnt_nxt  = cnt_add;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + POS_W'(1);
        end else begin
          col_nxt = col_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      csum_r <= '0;
      rsum_r <= '0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      csum_r <= csum_nxt;
      rsum_r <= rsum_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= pix_accept && frame_end;
    end
  end

  // totals including the last pixel of the frame
  always_ff @(posedge clk) begin
    if (pix_accept && frame_end) begin
      snap_r.col_sum   <= csum_add;
      snap_r.row_sum   <= rsum_add;
      snap_r.hit_count <= cnt_add;
    end
  end

  assign frame_tot  = snap_r;
  assign frame_done = done_r;

endmodule

`default_nettype wire

@@ hw/rtl/pmc_divider.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on pmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmc_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pmc_pkg::SUM_W-1:0]  dividend,
  input  wire logic [pmc_pkg::CNT_W-1:0]  divisor,
  output pmc_pkg::div_stat_t              stat,
  output logic [pmc_pkg::SUM_W-1:0]       quotient
);
  import pmc_pkg::*;

  logic [SUM_W-1:0]     quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;

  logic [CNT_W:0]       rem_sh, diff;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[SUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

@@ hw/rtl/pixel_match_centroid_core.sv @@
// pixel match centroid: top level with the division sequencer and output register
// depends on pmc_pkg, pmc_accum, pmc_divider
//
// usage:
//   in_valid/in_stall/in_pixel carry one gray pixel per beat in raster order.
//   out_valid/out_stall carry one result beat per frame: centroid_x, centroid_y,
//   match_count and found. cfg_we/cfg_index/cfg_data write frame_width (0),
//   frame_height (1) and match_value (2); other indexes are ignored.
//   pixels inside a frame are taken one per cycle. after the last pixel of a
//   frame the block stalls the input while one shared restoring divider forms
//   x then y, one quotient bit per cycle over 36 bits each. out_valid rises as
//   the output register loads, and the input opens again in the same cycle.
//   a result waits in the output register while out_stall is high; pixels of
//   the next frame keep flowing, and only a further frame end waits for it.
//   reset (rst_n low, synchronous) clears positions, sums and count, drops any
//   pending result and restores the register defaults 1200, 530 and 100.
//   with no matching pixel the centroid reads 0 and found is 0.
`timescale 1ns / 1ps
`default_nettype none

module pixel_match_centroid_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [pmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pmc_pkg::PIX_W-1:0]         in_pixel,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [pmc_pkg::COORD_W-1:0]            out_centroid_x,
  output logic [pmc_pkg::COORD_W-1:0]            out_centroid_y,
  output logic [pmc_pkg::CNT_W-1:0]              out_match_count,
  output logic                                   out_found
);
  import pmc_pkg::*;

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_DIVX = 4'b0010,
    ST_DIVY = 4'b0100,
    ST_HOLD = 4'b1000
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  frame_tot_t        frame_tot;
  logic              frame_done;
  div_stat_t         div_stat;
  logic [SUM_W-1:0]  quotient;
  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  logic              pix_accept;
  logic              out_free;
  logic              load_out;

  logic [COORD_W-1:0] qx_r, qy_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] out_cx_r, out_cy_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_found_r;
  logic               found;

  assign in_stall   = (state_r != ST_ACC) || frame_done;
  assign pix_accept = in_valid && !in_stall;

  pmc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_accept (pix_accept),
    .pixel      (in_pixel),
    .frame_tot  (frame_tot),
    .frame_done (frame_done)
  );

  pmc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (frame_tot.hit_count),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign found    = (frame_tot.hit_count != '0);

  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = frame_tot.col_sum;
    load_out     = 1'b0;
    case (state_r)
      ST_ACC: begin
        if (frame_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (div_stat.done) begin
          div_start    = 1'b1;
          div_dividend = frame_tot.row_sum;
          state_nxt    = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_stat.done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIVX && div_stat.done) begin
      qx_r <= quotient[COORD_W-1:0];
    end
    if (state_r == ST_DIVY && div_stat.done) begin
      qy_r <= quotient[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cx_r    <= found ? qx_r : '0;
      out_cy_r    <= found ? qy_r : '0;
      out_cnt_r   <= frame_tot.hit_count;
      out_found_r <= found;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_centroid_x  = out_cx_r;
  assign out_centroid_y  = out_cy_r;
  assign out_match_count = out_cnt_r;
  assign out_found       = out_found_r;

`ifndef ASSERT_OFF
  // no pixel may slip in while a frame's totals are being divided
  a_no_pix_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    pix_accept |-> !div_stat.busy && state_r == ST_ACC)
    else $error("pixel accepted during division");

  // the divider is only restarted when idle or just finished
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // a frame end is only flagged while accumulating
  a_done_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> state_r == ST_ACC)
    else $error("frame end outside accumulate state");

  // an empty frame reports a zero centroid
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_cx_r == '0 && out_cy_r == '0 && out_cnt_r == '0))
    else $error("empty frame with nonzero result");

  // loading the output never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for pixel_match_centroid_core: drives pixel beats, predicts each
// frame centroid and compares it with the result channel; depends on pmc_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import pmc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PIXELS = 120;
  localparam int OVERSIZE_PIXELS = 8;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CNT_W-1:0]   count;
    logic               found;
  } centroid_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;  // register data, or the pixel in the low byte
    logic                  typed;
    centroid_t             want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_W-1:0]    out_centroid_x;
  logic [COORD_W-1:0]    out_centroid_y;
  logic [CNT_W-1:0]      out_match_count;
  logic                  out_found;

  // shadow of the block: registers, positions and sums
  logic [SIZE_W-1:0] width_reg = RST_FRAME_WIDTH;
  logic [SIZE_W-1:0] height_reg = RST_FRAME_HEIGHT;
  logic [PIX_W-1:0]  match_reg = RST_MATCH_VALUE;
  logic [POS_W-1:0]  col_pos = '0;
  logic [POS_W-1:0]  row_pos = '0;
  logic [SUM_W-1:0]  col_acc = '0;
  logic [SUM_W-1:0]  row_acc = '0;
  logic [CNT_W-1:0]  hit_acc = '0;

  centroid_t pending_centroids[$];
  stim_row_t directed_rows[$];

  int errors = 0;
  int frames_checked = 0;
  int pixels_sent = 0;
  int writes_done = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit busy_since_settle = 1'b0;

  pixel_match_centroid_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_centroid_x  (out_centroid_x),
    .out_centroid_y  (out_centroid_y),
    .out_match_count (out_match_count),
    .out_found       (out_found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                 input logic [SUM_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // zero means one, anything past the limit saturates
  function automatic int effective_size(input logic [SIZE_W-1:0] v, input int lim);
    int r;
    r = (v == '0) ? 1 : int'(v);
    return (r > lim) ? lim : r;
  endfunction

  task automatic accumulate_pixel(input logic [PIX_W-1:0] px, output bit emits,
                                  output centroid_t res);
    int w;
    int h;
    bit row_end;
    w = effective_size(width_reg, MAX_WIDTH);
    h = effective_size(height_reg, MAX_HEIGHT);
    emits = 1'b0;
    res = '0;
    if (px == match_reg) begin
      col_acc = col_acc + SUM_W'(col_pos);
      row_acc = row_acc + SUM_W'(row_pos);
      hit_acc = hit_acc + 1'b1;
    end
    // a position already past a shrunk size closes the row or frame at once
    row_end = (int'(col_pos) + 1) >= w;
    if (row_end && (int'(row_pos) + 1) >= h) begin
      emits = 1'b1;
      res.count = hit_acc;
      if (hit_acc != '0) begin
        res.x = COORD_W'(col_acc / SUM_W'(hit_acc));
        res.y = COORD_W'(row_acc / SUM_W'(hit_acc));
        res.found = 1'b1;
      end
      col_pos = '0;
      row_pos = '0;
      col_acc = '0;
      row_acc = '0;
      hit_acc = '0;
    end else if (row_end) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  // called and returns at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                            input centroid_t want);
    bit emits;
    centroid_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_pixel <= PIX_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    accumulate_pixel(px, emits, res);
    if (emits) begin
      pending_centroids.push_back(typed ? want : res);
    end
    pixels_sent++;
    busy_since_settle = 1'b1;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_centroids.size() != 0) @(negedge clk);
    // a partial frame may still be inside the accumulator
    repeat (SETTLE_CYCLES) @(negedge clk);
    busy_since_settle = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    if (busy_since_settle) begin
      settle();
    end
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      REG_MATCH_VALUE:  match_reg = val[PIX_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    directed_rows.push_back('{ROW_WRITE, idx, val, 1'b0, centroid_t'('0)});
  endfunction

  function automatic void add_pixel(input logic [PIX_W-1:0] px);
    directed_rows.push_back('{ROW_PIXEL, REG_SPARE, CFG_DATA_W'(px), 1'b0, centroid_t'('0)});
  endfunction

  function automatic void add_pixel_want(input logic [PIX_W-1:0] px, input int x, input int y,
                                         input int count, input bit found);
    directed_rows.push_back('{ROW_PIXEL, REG_SPARE, CFG_DATA_W'(px), 1'b1,
                              centroid_t'{COORD_W'(x), COORD_W'(y), CNT_W'(count), found}});
  endfunction

  // 35 in 100 the match value, 7 a one-bit miss of it, the rest anything
  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(99);
    if (r < 35) return match_reg;
    if (r < 42) return match_reg ^ (8'h01 << $urandom_range(7));
    return PIX_W'($urandom);
  endfunction

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    centroid_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_centroids.size() == 0) begin
        report_mismatch("result beat with nothing expected", SUM_W'(out_match_count), '0);
      end else begin
        exp_c = pending_centroids.pop_front();
        if (out_centroid_x !== exp_c.x)
          report_mismatch("centroid_x", SUM_W'(out_centroid_x), SUM_W'(exp_c.x));
        if (out_centroid_y !== exp_c.y)
          report_mismatch("centroid_y", SUM_W'(out_centroid_y), SUM_W'(exp_c.y));
        if (out_match_count !== exp_c.count)
          report_mismatch("match_count", SUM_W'(out_match_count), SUM_W'(exp_c.count));
        if (out_found !== exp_c.found)
          report_mismatch("found", SUM_W'(out_found), SUM_W'(exp_c.found));
        frames_checked++;
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers, then shrink the frame under a partial row
    add_pixel(8'd100);
    add_pixel(8'd7);
    add_pixel(8'd100);
    add_pixel(8'd255);
    add_pixel(8'd0);
    add_write(REG_FRAME_WIDTH, 13'd2);
    add_write(REG_FRAME_HEIGHT, 13'd2);
    add_pixel(8'd100);
    add_pixel(8'd0);
    add_pixel(8'd100);
    // zero sizes act as one, so every beat closes a frame
    add_write(REG_FRAME_WIDTH, 13'd0);
    add_write(REG_FRAME_HEIGHT, 13'd0);
    add_write(REG_MATCH_VALUE, 13'd0);
    add_pixel_want(8'd0, 0, 0, 1, 1'b1);
    add_pixel_want(8'd255, 0, 0, 0, 1'b0);
    // only the low byte of the data lands in the match value
    add_write(REG_MATCH_VALUE, 13'h1FFF);
    add_pixel_want(8'd255, 0, 0, 1, 1'b1);
    add_pixel_want(8'd0, 0, 0, 0, 1'b0);
    // spare index is dropped
    add_write(REG_SPARE, 13'h00AA);
    add_pixel_want(8'd255, 0, 0, 1, 1'b1);
    add_write(REG_FRAME_WIDTH, 13'd3);
    add_write(REG_FRAME_HEIGHT, 13'd2);
    add_write(REG_MATCH_VALUE, 13'h05A);
    add_pixel(8'h5A);
    add_pixel(8'h00);
    add_pixel(8'h5A);
    add_pixel(8'hFF);
    add_pixel(8'h5A);
    add_pixel(8'h5A);
    add_write(REG_FRAME_WIDTH, 13'd1);
    add_write(REG_FRAME_HEIGHT, 13'd3);
    add_write(REG_MATCH_VALUE, 13'h080);
    add_pixel(8'h80);
    add_pixel(8'h7F);
    add_pixel_want(8'h80, 0, 1, 2, 1'b1);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.index, row.value);
      end else begin
        send_pixel(row.value[PIX_W-1:0], row.typed, row.want);
      end
    end

    // small random frames; partial frames carry over into the next size
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int part = 0; part < 4; part++) begin
        write_reg(REG_FRAME_WIDTH,
                  ($urandom_range(9) == 0) ? 13'd0 : CFG_DATA_W'($urandom_range(1, 8)));
        write_reg(REG_FRAME_HEIGHT,
                  ($urandom_range(9) == 0) ? 13'd0 : CFG_DATA_W'($urandom_range(1, 6)));
        write_reg(REG_MATCH_VALUE, CFG_DATA_W'($urandom));
        if ($urandom_range(3) == 0) begin
          write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        end
        repeat (RANDOM_PIXELS) send_pixel(pick_pixel(), 1'b0, '0);
      end
    end

    // oversized registers saturate, then a shrink below the position ends the frame at once
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    write_reg(REG_MATCH_VALUE, CFG_DATA_W'($urandom));
    repeat (OVERSIZE_PIXELS) send_pixel(pick_pixel(), 1'b0, '0);
    write_reg(REG_FRAME_WIDTH, 13'd2);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    send_pixel(pick_pixel(), 1'b0, '0);

    settle();
    $display("%0d pixel beats and %0d register writes drove %0d checked frame results",
             pixels_sent, writes_done, frames_checked);
    $display("frames from 1x1 to 8x6, zero and oversized sizes, mid-frame resizes, "
             , "four idle/stall mixes");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timed out with %0d results outstanding", pending_centroids.size());
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pmc_pkg.sv
hw/rtl/pmc_accum.sv
hw/rtl/pmc_divider.sv
hw/rtl/pixel_match_centroid_core.sv
bench/testbench.sv
